@@ hdl/itl_pkg.sv @@
// Shared types, token kind codes and keyword lookup for the token lexer.
// Used by the front, queue, back, top level and checker; no dependencies.
package itl_pkg;

  localparam int KIND_BITS   = 6;
  localparam int LINE_W      = 16;
  localparam int START_W     = 24;
  localparam int LEN_W       = 16;
  localparam int KW_BUF_BITS = 128;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LENGTH_LIMIT = {LEN_W{1'b1}};

  localparam logic [KIND_BITS-1:0] KIND_END        = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_SERVICE    = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_STRUCT     = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_ENUM       = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_VERSION    = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_DIRECTION  = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_ONEWAY     = 6'd6;
  localparam logic [KIND_BITS-1:0] KIND_ASYNC      = 6'd7;
  localparam logic [KIND_BITS-1:0] KIND_CLIENT     = 6'd8;
  localparam logic [KIND_BITS-1:0] KIND_SERVER     = 6'd9;
  localparam logic [KIND_BITS-1:0] KIND_BOTH       = 6'd10;
  localparam logic [KIND_BITS-1:0] KIND_INTEGER    = 6'd11;
  localparam logic [KIND_BITS-1:0] KIND_IDENTIFIER = 6'd12;
  localparam logic [KIND_BITS-1:0] KIND_VOID       = 6'd13;
  localparam logic [KIND_BITS-1:0] KIND_BOOL       = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_INT8       = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_INT16      = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_INT32      = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_INT64      = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_UINT8      = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_UINT16     = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_UINT32     = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_UINT64     = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_STRING     = 6'd23;
  localparam logic [KIND_BITS-1:0] KIND_ARRAY      = 6'd24;
  localparam logic [KIND_BITS-1:0] KIND_MAP        = 6'd25;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 6'd26;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 6'd27;
  localparam logic [KIND_BITS-1:0] KIND_LBRACKET   = 6'd28;
  localparam logic [KIND_BITS-1:0] KIND_RBRACKET   = 6'd29;
  localparam logic [KIND_BITS-1:0] KIND_LANGLE     = 6'd30;
  localparam logic [KIND_BITS-1:0] KIND_RANGLE     = 6'd31;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN     = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN     = 6'd33;
  localparam logic [KIND_BITS-1:0] KIND_SEMICOLON  = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_COMMA      = 6'd35;
  localparam logic [KIND_BITS-1:0] KIND_EQUAL      = 6'd36;
  localparam logic [KIND_BITS-1:0] KIND_ERROR      = 6'd37;

  // one queue entry: an optional flushed word plus an optional single token
  typedef struct packed {
    logic                 has_word;
    logic [KIND_BITS-1:0] word_kind;
    logic [START_W-1:0]   word_start;
    logic [LEN_W-1:0]     word_len;
    logic                 has_single;
    logic [KIND_BITS-1:0] single_kind;
    logic [START_W-1:0]   single_start;
    logic [LEN_W-1:0]     single_len;
    logic [LINE_W-1:0]    line;
  } entry_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [LINE_W-1:0]    line;
    logic [START_W-1:0]   start;
    logic [LEN_W-1:0]     len;
    logic                 last;
  } token_t;

  // word text is right aligned: last byte in the low byte, zeros above
  function automatic logic [KIND_BITS-1:0] kw_kind(input logic [KW_BUF_BITS-1:0] w);
    logic [KIND_BITS-1:0] k;
    case (w)
      KW_BUF_BITS'("service"):   k = KIND_SERVICE;
      KW_BUF_BITS'("struct"):    k = KIND_STRUCT;
      KW_BUF_BITS'("enum"):      k = KIND_ENUM;
      KW_BUF_BITS'("version"):   k = KIND_VERSION;
      KW_BUF_BITS'("direction"): k = KIND_DIRECTION;
      KW_BUF_BITS'("oneway"):    k = KIND_ONEWAY;
      KW_BUF_BITS'("async"):     k = KIND_ASYNC;
      KW_BUF_BITS'("client"):    k = KIND_CLIENT;
      KW_BUF_BITS'("server"):    k = KIND_SERVER;
      KW_BUF_BITS'("both"):      k = KIND_BOTH;
      KW_BUF_BITS'("void"):      k = KIND_VOID;
      KW_BUF_BITS'("bool"):      k = KIND_BOOL;
      KW_BUF_BITS'("int8"):      k = KIND_INT8;
      KW_BUF_BITS'("int16"):     k = KIND_INT16;
      KW_BUF_BITS'("int32"):     k = KIND_INT32;
      KW_BUF_BITS'("int64"):     k = KIND_INT64;
      KW_BUF_BITS'("uint8"):     k = KIND_UINT8;
      KW_BUF_BITS'("uint16"):    k = KIND_UINT16;
      KW_BUF_BITS'("uint32"):    k = KIND_UINT32;
      KW_BUF_BITS'("uint64"):    k = KIND_UINT64;
      KW_BUF_BITS'("string"):    k = KIND_STRING;
      KW_BUF_BITS'("array"):     k = KIND_ARRAY;
      KW_BUF_BITS'("map"):       k = KIND_MAP;
      default:                   k = KIND_IDENTIFIER;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      "<":     k = KIND_LANGLE;
      ">":     k = KIND_RANGLE;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ";":     k = KIND_SEMICOLON;
      ",":     k = KIND_COMMA;
      "=":     k = KIND_EQUAL;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/itl_front.sv @@
// Lexer front: accepts bytes, tracks position, line, comment and word state,
// and pushes one queue entry per byte or end item that yields tokens. Uses itl_pkg.
module itl_front #(
  parameter int POSITION_BITS = 24,
  parameter int LINE_BITS     = 16,
  parameter int KEYWORD_MAX   = 9
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  logic            q_ready,
  output logic            push,
  output itl_pkg::entry_t push_entry
);

  localparam int BUF_BITS = KEYWORD_MAX * 8;
  localparam logic [itl_pkg::LEN_W-1:0] KW_MAX_L = itl_pkg::LEN_W'(KEYWORD_MAX);
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  logic [POSITION_BITS-1:0] read_pos_r;
  logic [LINE_BITS-1:0]     line_r;
  logic                     in_comment_r;
  logic                     in_word_r;
  logic [POSITION_BITS-1:0] word_start_r;
  logic [itl_pkg::LEN_W-1:0] word_len_r;
  logic [itl_pkg::LEN_W-1:0] word_len_nxt;
  logic                     word_num_r;
  logic                     word_long_r;
  logic [BUF_BITS-1:0]      word_buf_r;

  logic accept, is_word, is_digit, is_ws, is_nl, is_slash;
  logic has_word, has_single;
  logic [LINE_BITS-1:0] line_inc;
  logic [itl_pkg::KIND_BITS-1:0] wkind;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  assign is_digit = (in_byte >= "0") && (in_byte <= "9");
  assign is_word  = ((in_byte >= "a") && (in_byte <= "z")) ||
                    ((in_byte >= "A") && (in_byte <= "Z")) || is_digit || (in_byte == "_");
  assign is_ws    = (in_byte == " ") || (in_byte == 8'h09);
  assign is_nl    = (in_byte == 8'h0A);
  assign is_slash = (in_byte == "/");

  assign line_inc     = (line_r != LINE_MAX) ? line_r + 1'b1 : line_r;
  assign word_len_nxt = (word_len_r != itl_pkg::LENGTH_LIMIT) ? word_len_r + 1'b1 : word_len_r;

  always_comb begin
    if (word_num_r) begin
      wkind = itl_pkg::KIND_INTEGER;
    end else if (word_long_r) begin
      wkind = itl_pkg::KIND_IDENTIFIER;
    end else begin
      wkind = itl_pkg::kw_kind(itl_pkg::KW_BUF_BITS'(word_buf_r));
    end
  end

  assign has_word   = in_word_r && (in_end || (!in_comment_r && !is_word));
  assign has_single = in_end || (!in_comment_r && !is_word && !is_ws && !is_nl && !is_slash);
  assign push       = accept && (has_word || has_single);

  always_comb begin
    push_entry.has_word     = has_word;
    push_entry.word_kind    = wkind;
    push_entry.word_start   = itl_pkg::START_W'(word_start_r);
    push_entry.word_len     = word_len_r;
    push_entry.has_single   = has_single;
    push_entry.single_kind  = in_end ? itl_pkg::KIND_END : itl_pkg::punct_kind(in_byte);
    push_entry.single_start = itl_pkg::START_W'(read_pos_r);
    push_entry.single_len   = in_end ? '0 : itl_pkg::LEN_W'(1);
    push_entry.line         = itl_pkg::LINE_W'(line_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_pos_r   <= '0;
      line_r       <= '0;
      in_comment_r <= 1'b0;
      in_word_r    <= 1'b0;
      word_start_r <= '0;
      word_len_r   <= '0;
      word_num_r   <= 1'b0;
      word_long_r  <= 1'b0;
    end else if (accept) begin
      if (in_end) begin
        in_word_r    <= 1'b0;
        in_comment_r <= 1'b0;
      end else begin
        read_pos_r <= read_pos_r + 1'b1;
        if (in_comment_r) begin
          if (is_nl) begin
            in_comment_r <= 1'b0;
            line_r       <= line_inc;
          end
        end else if (is_word) begin
          if (!in_word_r) begin
            in_word_r    <= 1'b1;
            word_start_r <= read_pos_r;
            word_len_r   <= itl_pkg::LEN_W'(1);
            word_num_r   <= is_digit;
            word_long_r  <= 1'b0;
          end else begin
            word_len_r <= word_len_nxt;
            if (word_len_nxt > KW_MAX_L) begin
              word_long_r <= 1'b1;
            end
          end
        end else begin
          in_word_r <= 1'b0;
          if (is_nl) begin
            line_r <= line_inc;
          end
          if (is_slash) begin
            in_comment_r <= 1'b1;
          end
        end
      end
    end
  end

  // word text buffer, right aligned; no reset, always written on word start
  always_ff @(posedge clk) begin
    if (accept && !in_end && !in_comment_r && is_word) begin
      if (!in_word_r) begin
        word_buf_r <= BUF_BITS'(in_byte);
      end else if (word_len_nxt <= KW_MAX_L) begin
        word_buf_r <= {word_buf_r[BUF_BITS-9:0], in_byte};
      end
    end
  end

endmodule

@@ hdl/itl_queue.sv @@
// Short entry queue between the lexer front and the token back end.
// Uses itl_pkg for the entry type and depth.
module itl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  itl_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output logic            head_valid,
  output itl_pkg::entry_t head_entry
);

  localparam logic [itl_pkg::QPTR_BITS-1:0] PTR_LAST = itl_pkg::QPTR_BITS'(itl_pkg::QUEUE_DEPTH - 1);
  localparam logic [itl_pkg::QCNT_BITS-1:0] CNT_FULL = itl_pkg::QCNT_BITS'(itl_pkg::QUEUE_DEPTH);

  itl_pkg::entry_t entries_r [itl_pkg::QUEUE_DEPTH];
  logic [itl_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [itl_pkg::QCNT_BITS-1:0] count_r;

  assign push_ready = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/itl_back.sv @@
// Token back end: splits queue entries into one or two tokens and holds
// each in an output register until the receiver takes it. Uses itl_pkg.
module itl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  itl_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output itl_pkg::token_t out_token
);

  logic            phase_r;
  logic            out_valid_r;
  itl_pkg::token_t token_r;
  logic            load, send_word;

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign send_word = head_entry.has_word && !phase_r;
  assign pop       = load && !(send_word && head_entry.has_single);
  assign out_valid = out_valid_r;
  assign out_token = token_r;

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_word) begin
        token_r.kind  <= head_entry.word_kind;
        token_r.start <= head_entry.word_start;
        token_r.len   <= head_entry.word_len;
        token_r.last  <= !head_entry.has_single;
      end else begin
        token_r.kind  <= head_entry.single_kind;
        token_r.start <= head_entry.single_start;
        token_r.len   <= head_entry.single_len;
        token_r.last  <= 1'b1;
      end
      token_r.line <= head_entry.line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= send_word && head_entry.has_single;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/idl_token_lexer_top.sv @@
// Top level of the interface-language token lexer.
// Depends on itl_pkg, itl_front, itl_queue and itl_back.
//
// Usage:
//   Input stream: one source byte per transfer in in_tdata; in_tuser high
//   marks an end item (byte ignored) that flushes a pending word and then
//   yields an end token.
//   Output stream: one token per transfer; out_tlast marks the final token
//   caused by one input item. A byte gives zero, one or two tokens.
//   Path: a token completed by a byte transfer passes through the queue and
//   then the output register before its earliest transfer; words appear
//   when their terminator arrives.
//   Throughput: one byte per cycle while the queue has room, set by the
//   per-byte classify and parallel keyword compare in the front; items
//   with two tokens need two output transfers, and a four-entry queue absorbs such bursts.
//   Reset (rst_n low, synchronous) clears position, line and word state
//   and empties the queue and output register.
//   When the receiver stalls, the output register holds its token, the
//   queue fills, and in_tready drops once the queue is full.
module idl_token_lexer_top #(
  parameter int POSITION_BITS = 24,
  parameter int LINE_BITS     = 16,
  parameter int KEYWORD_MAX   = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] is_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [5:0] token_kind, [21:6] line_number,
                                  // [45:22] token_start, [61:46] token_length
  output logic        out_tlast
);

  logic            push, q_ready, pop, head_valid;
  itl_pkg::entry_t push_entry, head_entry;
  itl_pkg::token_t token;

  itl_front #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS    (LINE_BITS),
    .KEYWORD_MAX  (KEYWORD_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_end    (in_tuser),
    .q_ready   (q_ready),
    .push      (push),
    .push_entry(push_entry)
  );

  itl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .push_ready(q_ready),
    .pop       (pop),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  itl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_token (token)
  );

  assign out_tdata = {2'b00, token.len, token.start, token.line, token.kind};
  assign out_tlast = token.last;

endmodule

@@ hdl/itl_checker.sv @@
// Port-level checker for the token lexer, bound to idl_token_lexer_top.
// Depends on itl_pkg for the token kind codes.
module itl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  logic [itl_pkg::KIND_BITS-1:0] kind;
  logic [itl_pkg::LEN_W-1:0]     len;

  assign kind = out_tdata[5:0];
  assign len  = out_tdata[61:46];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled token changed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kind == itl_pkg::KIND_END) |-> out_tlast && (len == '0))
    else $error("end token not last or not empty");

  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kind >= itl_pkg::KIND_LBRACE) |-> out_tlast && (len == 16'd1))
    else $error("punctuation or error token malformed");

  a_word_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (kind >= itl_pkg::KIND_SERVICE) &&
                                 (kind <= itl_pkg::KIND_MAP) && (len != '0))
    else $error("non-final token is not a word");

endmodule

bind idl_token_lexer_top itl_checker u_itl_checker (.*);

@@ tb/lex_token_check.sv @@
`timescale 1ns / 1ps
// Token checker for the interface-language lexer: watches both streams, predicts the
// tokens of every accepted byte transfer and compares them with the output transfers.
// Depends on itl_pkg for the token kind codes and the token struct.
module lex_token_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          tokens_pending
);

  logic [itl_pkg::START_W-1:0] read_pos;
  logic [itl_pkg::LINE_W-1:0]  line_cnt;
  logic                        in_comment;
  logic                        in_word;
  logic                        word_num;
  logic                        word_long;
  logic [itl_pkg::START_W-1:0] word_start;
  logic [itl_pkg::LEN_W-1:0]   word_len;
  logic [71:0]                 word_text;   // right aligned, newest byte lowest
  itl_pkg::token_t             expected_tokens[$];
  itl_pkg::token_t             got_token;
  int                          errors;

  function automatic logic [itl_pkg::KIND_BITS-1:0] keyword_kind(input logic [71:0] w);
    case (w)
      "service":   return itl_pkg::KIND_SERVICE;
      "struct":    return itl_pkg::KIND_STRUCT;
      "enum":      return itl_pkg::KIND_ENUM;
      "version":   return itl_pkg::KIND_VERSION;
      "direction": return itl_pkg::KIND_DIRECTION;
      "oneway":    return itl_pkg::KIND_ONEWAY;
      "async":     return itl_pkg::KIND_ASYNC;
      "client":    return itl_pkg::KIND_CLIENT;
      "server":    return itl_pkg::KIND_SERVER;
      "both":      return itl_pkg::KIND_BOTH;
      "void":      return itl_pkg::KIND_VOID;
      "bool":      return itl_pkg::KIND_BOOL;
      "int8":      return itl_pkg::KIND_INT8;
      "int16":     return itl_pkg::KIND_INT16;
      "int32":     return itl_pkg::KIND_INT32;
      "int64":     return itl_pkg::KIND_INT64;
      "uint8":     return itl_pkg::KIND_UINT8;
      "uint16":    return itl_pkg::KIND_UINT16;
      "uint32":    return itl_pkg::KIND_UINT32;
      "uint64":    return itl_pkg::KIND_UINT64;
      "string":    return itl_pkg::KIND_STRING;
      "array":     return itl_pkg::KIND_ARRAY;
      "map":       return itl_pkg::KIND_MAP;
      default:     return itl_pkg::KIND_IDENTIFIER;
    endcase
  endfunction

  function automatic logic [itl_pkg::KIND_BITS-1:0] symbol_kind(input logic [7:0] c);
    case (c)
      "{":     return itl_pkg::KIND_LBRACE;
      "}":     return itl_pkg::KIND_RBRACE;
      "[":     return itl_pkg::KIND_LBRACKET;
      "]":     return itl_pkg::KIND_RBRACKET;
      "<":     return itl_pkg::KIND_LANGLE;
      ">":     return itl_pkg::KIND_RANGLE;
      "(":     return itl_pkg::KIND_LPAREN;
      ")":     return itl_pkg::KIND_RPAREN;
      ";":     return itl_pkg::KIND_SEMICOLON;
      ",":     return itl_pkg::KIND_COMMA;
      "=":     return itl_pkg::KIND_EQUAL;
      default: return itl_pkg::KIND_ERROR;
    endcase
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  task automatic bump_line();
    if (line_cnt != {itl_pkg::LINE_W{1'b1}})
      line_cnt = line_cnt + 1'b1;
  endtask

  task automatic lex_transfer(input logic [7:0] c, input logic is_end);
    itl_pkg::token_t tok[2];
    int              n;
    bit              wc;
    n  = 0;
    wc = is_word_char(c);
    if (in_word && (is_end || (!in_comment && !wc))) begin
      tok[n].kind  = word_num ? itl_pkg::KIND_INTEGER :
                     word_long ? itl_pkg::KIND_IDENTIFIER : keyword_kind(word_text);
      tok[n].line  = line_cnt;
      tok[n].start = word_start;
      tok[n].len   = word_len;
      tok[n].last  = 1'b0;
      n++;
      in_word = 1'b0;
    end
    if (is_end) begin
      in_comment = 1'b0;
      tok[n] = '{itl_pkg::KIND_END, line_cnt, read_pos, {itl_pkg::LEN_W{1'b0}}, 1'b0};
      n++;
    end else begin
      if (in_comment) begin
        if (c == "\n") begin
          in_comment = 1'b0;
          bump_line();
        end
      end else if (wc) begin
        if (!in_word) begin
          in_word    = 1'b1;
          word_start = read_pos;
          word_len   = 16'd1;
          word_num   = (c >= "0" && c <= "9");
          word_long  = 1'b0;
          word_text  = {64'd0, c};
        end else begin
          if (word_len != itl_pkg::LENGTH_LIMIT)
            word_len = word_len + 1'b1;
          if (word_len <= 16'd9)
            word_text = {word_text[63:0], c};
          else
            word_long = 1'b1;
        end
      end else if (c == " " || c == "\t") begin
      end else if (c == "\n") begin
        bump_line();
      end else if (c == "/") begin
        in_comment = 1'b1;
      end else begin
        tok[n] = '{symbol_kind(c), line_cnt, read_pos, 16'd1, 1'b0};
        n++;
      end
      read_pos = read_pos + 1'b1;
    end
    if (n > 0)
      tok[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      expected_tokens.push_back(tok[i]);
  endtask

  task automatic field_diff(input string name, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_token(input itl_pkg::token_t got);
    itl_pkg::token_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token, expected none, actual kind %0d line %0d start %0d len %0d",
               $time, got.kind, got.line, got.start, got.len);
      errors++;
    end else begin
      want = expected_tokens.pop_front();
      field_diff("token_kind", 32'(want.kind), 32'(got.kind));
      field_diff("line_number", 32'(want.line), 32'(got.line));
      field_diff("token_start", 32'(want.start), 32'(got.start));
      field_diff("token_length", 32'(want.len), 32'(got.len));
      field_diff("last_of_run", 32'(want.last), 32'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      read_pos   = '0;
      line_cnt   = '0;
      in_comment = 1'b0;
      in_word    = 1'b0;
      word_num   = 1'b0;
      word_long  = 1'b0;
      word_start = '0;
      word_len   = '0;
      word_text  = '0;
      expected_tokens.delete();
    end else begin
      if (in_tvalid && in_tready)
        lex_transfer(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        got_token.kind  = out_tdata[5:0];
        got_token.line  = out_tdata[21:6];
        got_token.start = out_tdata[45:22];
        got_token.len   = out_tdata[61:46];
        got_token.last  = out_tlast;
        check_token(got_token);
      end
    end
    mismatch_count <= errors;
    tokens_pending <= expected_tokens.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the interface-language token lexer: directed and random source
// text with bursty input and a stalling receiver. Depends on idl_token_lexer_top, lex_token_check.
module testbench;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 650;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  int          mismatch_count;
  int          tokens_pending;
  int          cycle_count;
  int          burst_left;
  int          bytes_sent;
  int          rx_cycles;
  bit          gaps_on;
  bit          hold_go;
  bit          hold_done;
  string       punct_chars = "{}[]<>();,=";
  string       keywords[23] = '{"service", "struct", "enum", "version", "direction",
                                "oneway", "async", "client", "server", "both", "void",
                                "bool", "int8", "int16", "int32", "int64", "uint8",
                                "uint16", "uint32", "uint64", "string", "array", "map"};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  idl_token_lexer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lex_token_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .tokens_pending (tokens_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: rotating stall modes, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rx_cycles++;
        case ((rx_cycles / 97) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (rx_cycles % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic e);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0)
      burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    case ($urandom_range(lead ? 1 : 0, 3))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("a" + $urandom_range(0, 25));
      2:       return 8'("A" + $urandom_range(0, 25));
      default: return "_";
    endcase
  endfunction

  task automatic send_separator();
    case ($urandom_range(0, 4))
      0:       send_item(" ", 1'b0);
      1:       send_item("\t", 1'b0);
      2:       send_item("\n", 1'b0);
      default: send_item(punct_chars[$urandom_range(0, 10)], 1'b0);
    endcase
  endtask

  task automatic send_chunk();
    int    n;
    string kw;
    case ($urandom_range(0, 12))
      0, 1, 2: begin
        send_text(keywords[$urandom_range(0, 22)]);
        send_separator();
      end
      3, 4: begin
        send_item(word_char(1'b1), 1'b0);
        n = $urandom_range(0, 11);
        repeat (n) send_item(word_char(1'b0), 1'b0);
        send_separator();
      end
      5: begin
        send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) send_item(word_char(1'b0), 1'b0);
        send_separator();
      end
      6: begin
        kw = keywords[$urandom_range(0, 22)];
        if ($urandom_range(0, 1) == 0)
          send_text(kw.substr(0, kw.len() - 2));
        else begin
          send_text(kw);
          send_item(word_char(1'b0), 1'b0);
        end
        send_separator();
      end
      7: send_item(punct_chars[$urandom_range(0, 10)], 1'b0);
      8: send_separator();
      9: begin
        send_item("/", 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item("\n", 1'b0);
      end
      10: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: send_item(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    gaps_on   = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // integer word, tab, every symbol, comment, space, word flushed by an error byte, error bytes, two end items
    send_text("9z_\t{}[]<>();,=/x\n ab");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h5A, 1'b1);

    while (bytes_sent < 25 + RANDOM_ITEMS) begin
      if (bytes_sent >= 250)
        hold_go = 1'b1;
      send_chunk();
    end

    // long word: never a keyword
    gaps_on = 1'b0;
    send_item("s", 1'b0);
    repeat (20) send_item(word_char(1'b0), 1'b0);
    send_item(";", 1'b0);

    send_text("enum x=");
    gaps_on = 1'b1;
    send_item(8'h00, 1'b1);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && tokens_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
